[rtl/core/mtp_pkg.sv]
// types and constants shared by the midi track parser modules
package mtp_pkg;

  typedef enum logic [8:0] {
    PH_DELTA      = 9'b000000001,
    PH_STATUS     = 9'b000000010,
    PH_KEY        = 9'b000000100,
    PH_VEL        = 9'b000001000,
    PH_SKIP       = 9'b000010000,
    PH_LEN        = 9'b000100000,
    PH_META_TYPE  = 9'b001000000,
    PH_TEMPO_LEN  = 9'b010000000,
    PH_TEMPO_DATA = 9'b100000000
  } phase_t;

  localparam logic [1:0] KIND_NOTE  = 2'd0;
  localparam logic [1:0] KIND_TEMPO = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_STATUS = 2'd1;
  localparam logic [1:0] ERR_TEMPO_LEN = 2'd2;

  localparam logic [7:0] ST_NOTE_ON   = 8'h90;
  localparam logic [7:0] ST_NOTE_LAST = 8'h9F;
  localparam logic [7:0] ST_ONE_DATA  = 8'hC0;
  localparam logic [7:0] ST_TWO_DATA  = 8'hE0;
  localparam logic [7:0] ST_SYSTEM    = 8'hF0;
  localparam logic [7:0] ST_META      = 8'hFF;
  localparam logic [7:0] META_TEMPO   = 8'h51;
  localparam logic [7:0] TEMPO_LENGTH = 8'h03;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tick_time;
    logic [3:0]  channel;
    logic [6:0]  key;
    logic [6:0]  velocity;
    logic [23:0] tempo;
    logic [1:0]  error_code;
    logic        last_result;
  } result_t;

  // results produced by one accepted byte
  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

[rtl/core/mtp_if.sv]
// valid/ready channel interfaces for track bytes and parser results
interface mtp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mtp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] tick_time;
  logic [3:0]  channel;
  logic [6:0]  key;
  logic [6:0]  velocity;
  logic [23:0] tempo;
  logic [1:0]  error_code;
  logic        last_result;

  modport source (output valid, output kind, output tick_time, output channel,
                  output key, output velocity, output tempo, output error_code,
                  output last_result, input ready);
  modport sink (input valid, input kind, input tick_time, input channel,
                input key, input velocity, input tempo, input error_code,
                input last_result, output ready);
endinterface

[rtl/core/midi_track_note_tempo_parser_top.sv]
// top level of the midi track note and tempo parser
//
//   channel  dir  payload                                        accepted when
//   track    in   data_byte[7:0], last_byte                      valid && ready
//   events   out  kind, tick_time, channel, key, velocity,       valid && ready
//                 tempo, error_code, last_result
//   apb      in   channel_tag at byte address 0                  psel && penable && pwrite
//
// while the queue has room, one byte is parsed per cycle in the cycle it is accepted;
// its results land in the result queue at that edge and can leave from the next cycle on.
// a byte gives at most two results; track.ready drops while the queue has
// fewer than two free slots, so output stalls back up into the byte stream.
// synchronous reset clears the parser, the queue and channel_tag.
module midi_track_note_tempo_parser_top import mtp_pkg::*; #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  mtp_byte_if.sink     track,
  mtp_result_if.source events,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam logic REG_CHANNEL_TAG = 1'b0;

  logic [3:0] channel_tag;
  logic       room;
  logic       accept;
  push_t      push;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHANNEL_TAG) ? {28'd0, channel_tag} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_tag <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_CHANNEL_TAG)) begin
      channel_tag <= pwdata[3:0];
    end
  end

  assign track.ready = room;
  assign accept      = track.valid && room;

  mtp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .channel_tag (channel_tag),
    .accept      (accept),
    .data_byte   (track.data_byte),
    .last_byte   (track.last_byte),
    .push        (push)
  );

  mtp_result_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .room (room),
    .res  (events)
  );

endmodule

[rtl/core/mtp_parser.sv]
// track byte parser: phase state, time and status tracking, result build
module mtp_parser import mtp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] channel_tag,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output push_t      push
);

  phase_t      phase, phase_next;
  logic [31:0] delta_accum, delta_accum_next;
  logic [31:0] abs_time, abs_time_next;
  logic [7:0]  running_status, running_status_next;
  logic        status_valid, status_valid_next;
  logic [7:0]  first_data, first_data_next;
  logic [27:0] skip_count, skip_count_next;
  logic [23:0] tempo_accum, tempo_accum_next;
  logic [1:0]  tempo_bytes_left, tempo_bytes_left_next;

  logic [31:0] delta_shift;
  logic [27:0] len_cont, len_fresh, skip_dec;
  logic [1:0]  tempo_left_dec;
  logic [23:0] tempo_shift;
  logic [7:0]  cur_status;
  logic        have_first;
  logic [1:0]  chan_len;
  logic        ev;
  result_t     ev_res, end_res;

  always_comb begin
    phase_next            = phase;
    delta_accum_next      = delta_accum;
    abs_time_next         = abs_time;
    running_status_next   = running_status;
    status_valid_next     = status_valid;
    first_data_next       = first_data;
    skip_count_next       = skip_count;
    tempo_accum_next      = tempo_accum;
    tempo_bytes_left_next = tempo_bytes_left;
    ev                    = 1'b0;
    ev_res                = '0;

    delta_shift    = {delta_accum[24:0], data_byte[6:0]};
    len_cont       = {skip_count[20:0], data_byte[6:0]};
    len_fresh      = {21'd0, data_byte[6:0]};
    skip_dec       = skip_count - 28'd1;
    tempo_left_dec = tempo_bytes_left - 2'd1;
    tempo_shift    = {tempo_accum[15:0], data_byte};
    // a data byte in status position reuses the running status
    have_first     = !data_byte[7];
    cur_status     = have_first ? running_status : data_byte;
    chan_len       = ((cur_status >= ST_ONE_DATA) && (cur_status < ST_TWO_DATA)) ? 2'd1 : 2'd2;
    chan_len       = chan_len - {1'b0, have_first};

    case (phase)
      PH_DELTA: begin
        if (data_byte[7]) begin
          delta_accum_next = delta_shift;
        end else begin
          abs_time_next    = abs_time + delta_shift;
          delta_accum_next = '0;
          phase_next       = PH_STATUS;
        end
      end
      PH_STATUS: begin
        if (data_byte[7] && (data_byte >= ST_SYSTEM)) begin
          status_valid_next = 1'b0;
          skip_count_next   = '0;
          phase_next        = (data_byte == ST_META) ? PH_META_TYPE : PH_LEN;
        end else if (data_byte[7] || status_valid) begin
          if (data_byte[7]) begin
            running_status_next = data_byte;
            status_valid_next   = 1'b1;
          end
          if (cur_status <= ST_NOTE_LAST) begin
            if (have_first) begin
              first_data_next = data_byte;
              phase_next      = PH_VEL;
            end else begin
              phase_next      = PH_KEY;
            end
          end else begin
            skip_count_next = {26'd0, chan_len};
            phase_next      = (chan_len == 2'd0) ? PH_DELTA : PH_SKIP;
          end
        end else begin
          ev                = 1'b1;
          ev_res.kind       = KIND_ERROR;
          ev_res.error_code = ERR_NO_STATUS;
          phase_next        = PH_DELTA;
        end
      end
      PH_KEY: begin
        first_data_next = data_byte;
        phase_next      = PH_VEL;
      end
      PH_VEL: begin
        ev             = 1'b1;
        ev_res.kind    = KIND_NOTE;
        ev_res.channel = channel_tag;
        ev_res.key     = first_data[6:0];
        if (running_status >= ST_NOTE_ON) begin
          ev_res.velocity = data_byte[6:0];
        end
        phase_next = PH_DELTA;
      end
      PH_SKIP: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_DELTA;
        end
      end
      PH_LEN: begin
        skip_count_next = len_cont;
        if (data_byte[7]) begin
          phase_next = PH_LEN;
        end else begin
          phase_next = (len_cont == '0) ? PH_DELTA : PH_SKIP;
        end
      end
      PH_META_TYPE: begin
        skip_count_next = '0;
        phase_next      = (data_byte == META_TEMPO) ? PH_TEMPO_LEN : PH_LEN;
      end
      PH_TEMPO_LEN: begin
        if (data_byte == TEMPO_LENGTH) begin
          tempo_accum_next      = '0;
          tempo_bytes_left_next = 2'd3;
          phase_next            = PH_TEMPO_DATA;
        end else begin
          ev                = 1'b1;
          ev_res.kind       = KIND_ERROR;
          ev_res.error_code = ERR_TEMPO_LEN;
          // the byte starts a fresh meta length
          skip_count_next   = len_fresh;
          if (data_byte[7]) begin
            phase_next = PH_LEN;
          end else begin
            phase_next = (len_fresh == '0) ? PH_DELTA : PH_SKIP;
          end
        end
      end
      PH_TEMPO_DATA: begin
        tempo_accum_next      = tempo_shift;
        tempo_bytes_left_next = tempo_left_dec;
        if (tempo_left_dec == 2'd0) begin
          ev           = 1'b1;
          ev_res.kind  = KIND_TEMPO;
          ev_res.tempo = tempo_shift;
          phase_next   = PH_DELTA;
        end
      end
      default: begin
        phase_next = PH_DELTA;
      end
    endcase

    ev_res.tick_time = abs_time_next;
    end_res           = '0;
    end_res.kind      = KIND_END;
    end_res.tick_time = abs_time_next;
    end_res.last_result = 1'b1;

    push.r0 = '0;
    push.r1 = '0;
    if (ev && last_byte) begin
      push.count = 2'd2;
      push.r0    = ev_res;
      push.r1    = end_res;
    end else if (ev) begin
      push.count = 2'd1;
      push.r0    = ev_res;
      push.r0.last_result = 1'b1;
    end else if (last_byte) begin
      push.count = 2'd1;
      push.r0    = end_res;
    end else begin
      push.count = 2'd0;
    end

    // end of track puts the parser back to its reset state
    if (last_byte) begin
      phase_next            = PH_DELTA;
      delta_accum_next      = '0;
      abs_time_next         = '0;
      running_status_next   = '0;
      status_valid_next     = 1'b0;
      first_data_next       = '0;
      skip_count_next       = '0;
      tempo_accum_next      = '0;
      tempo_bytes_left_next = '0;
    end

    if (!accept) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_DELTA;
      delta_accum      <= '0;
      abs_time         <= '0;
      running_status   <= '0;
      status_valid     <= 1'b0;
      first_data       <= '0;
      skip_count       <= '0;
      tempo_accum      <= '0;
      tempo_bytes_left <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      delta_accum      <= delta_accum_next;
      abs_time         <= abs_time_next;
      running_status   <= running_status_next;
      status_valid     <= status_valid_next;
      first_data       <= first_data_next;
      skip_count       <= skip_count_next;
      tempo_accum      <= tempo_accum_next;
      tempo_bytes_left <= tempo_bytes_left_next;
    end
  end

endmodule

[rtl/core/mtp_result_fifo.sv]
// result queue: takes up to two results a cycle, hands out one per transfer
module mtp_result_fifo import mtp_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  push_t        push,
  output logic         room,
  mtp_result_if.source res
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);

  result_t       slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr, wr_ptr2;
  logic [CW-1:0] count;
  logic          pop;
  result_t       head;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == LAST_IDX) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr2 = ptr_inc(wr_ptr);
  assign pop     = res.valid && res.ready;
  // a byte may need two slots
  assign room    = (count <= CW'(DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wr_ptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[wr_ptr2] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      case (push.count)
        2'd1:    wr_ptr <= wr_ptr2;
        2'd2:    wr_ptr <= ptr_inc(wr_ptr2);
        default: wr_ptr <= wr_ptr;
      endcase
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      count <= count + CW'(push.count) - CW'(pop);
    end
  end

  assign head            = slots[rd_ptr];
  assign res.valid       = (count != '0);
  assign res.kind        = head.kind;
  assign res.tick_time   = head.tick_time;
  assign res.channel     = head.channel;
  assign res.key         = head.key;
  assign res.velocity    = head.velocity;
  assign res.tempo       = head.tempo;
  assign res.error_code  = head.error_code;
  assign res.last_result = head.last_result;

endmodule

[tb/sv/tb.sv]
// self-checking testbench for the midi track note and tempo parser top level
`timescale 1ns / 100ps

module tb;
  import mtp_pkg::*;

  localparam logic [2:0] CHANNEL_TAG_ADDR = 3'd0;
  localparam int unsigned PHASE_BYTES = 413;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned REPORT_LIMIT = 100;

  // tracks the parser state byte by byte and holds the events still owed
  class track_event_scoreboard;
    phase_t      stage;
    logic [31:0] delta_acc;
    logic [31:0] abs_ticks;
    logic [7:0]  run_status;
    bit          status_ok;
    logic [7:0]  first_key;
    logic [27:0] skip_left;
    logic [23:0] tempo_acc;
    logic [1:0]  tempo_left;
    logic [3:0]  chan_tag;
    result_t     pending_events[$];
    result_t     fresh[$];
    int unsigned failures;

    function new();
      chan_tag = 4'd0;
      failures = 0;
      clear_parser();
    endfunction

    function void clear_parser();
      stage = PH_DELTA;
      delta_acc = '0;
      abs_ticks = '0;
      run_status = '0;
      status_ok = 1'b0;
      first_key = '0;
      skip_left = '0;
      tempo_acc = '0;
      tempo_left = '0;
    endfunction

    function void emit(logic [1:0] kind, logic [6:0] key, logic [6:0] vel,
                       logic [23:0] tempo, logic [1:0] err);
      result_t r;
      r.kind = kind;
      r.tick_time = abs_ticks;
      r.channel = (kind == KIND_NOTE) ? chan_tag : 4'd0;
      r.key = key;
      r.velocity = vel;
      r.tempo = tempo;
      r.error_code = err;
      r.last_result = 1'b0;
      fresh.insert(fresh.size(), r);
    endfunction

    function void load_length(logic [7:0] b);
      skip_left = {skip_left[20:0], b[6:0]};
      if (b[7]) stage = PH_LEN;
      else stage = (skip_left == 0) ? PH_DELTA : PH_SKIP;
    endfunction

    function void start_channel_event(logic [7:0] b, bit have_first);
      logic [27:0] len;
      if (run_status <= ST_NOTE_LAST) begin
        if (have_first) begin
          first_key = b;
          stage = PH_VEL;
        end else begin
          stage = PH_KEY;
        end
      end else begin
        len = (run_status >= ST_ONE_DATA && run_status < ST_TWO_DATA) ? 28'd1 : 28'd2;
        if (have_first) len = len - 28'd1;
        skip_left = len;
        stage = (len == 0) ? PH_DELTA : PH_SKIP;
      end
    endfunction

    function void take_byte(logic [7:0] b, bit last);
      fresh.delete();
      case (stage)
        PH_DELTA: begin
          delta_acc = {delta_acc[24:0], b[6:0]};
          if (!b[7]) begin
            abs_ticks = abs_ticks + delta_acc;
            delta_acc = '0;
            stage = PH_STATUS;
          end
        end
        PH_STATUS: begin
          if (b[7]) begin
            if (b < ST_SYSTEM) begin
              run_status = b;
              status_ok = 1'b1;
              start_channel_event(b, 1'b0);
            end else begin
              // sysex and meta drop running status
              status_ok = 1'b0;
              skip_left = '0;
              stage = (b == ST_META) ? PH_META_TYPE : PH_LEN;
            end
          end else if (status_ok) begin
            start_channel_event(b, 1'b1);
          end else begin
            emit(KIND_ERROR, 7'd0, 7'd0, 24'd0, ERR_NO_STATUS);
            stage = PH_DELTA;
          end
        end
        PH_KEY: begin
          first_key = b;
          stage = PH_VEL;
        end
        PH_VEL: begin
          emit(KIND_NOTE, first_key[6:0],
               (run_status >= ST_NOTE_ON && b[6:0] != 0) ? b[6:0] : 7'd0,
               24'd0, ERR_NONE);
          stage = PH_DELTA;
        end
        PH_SKIP: begin
          skip_left = skip_left - 28'd1;
          if (skip_left == 0) stage = PH_DELTA;
        end
        PH_LEN: load_length(b);
        PH_META_TYPE: begin
          skip_left = '0;
          stage = (b == META_TEMPO) ? PH_TEMPO_LEN : PH_LEN;
        end
        PH_TEMPO_LEN: begin
          if (b == TEMPO_LENGTH) begin
            tempo_acc = '0;
            tempo_left = 2'd3;
            stage = PH_TEMPO_DATA;
          end else begin
            // bad tempo length is reread as the start of a skip length
            emit(KIND_ERROR, 7'd0, 7'd0, 24'd0, ERR_TEMPO_LEN);
            skip_left = '0;
            load_length(b);
          end
        end
        PH_TEMPO_DATA: begin
          tempo_acc = {tempo_acc[15:0], b};
          tempo_left = tempo_left - 2'd1;
          if (tempo_left == 0) begin
            emit(KIND_TEMPO, 7'd0, 7'd0, tempo_acc, ERR_NONE);
            stage = PH_DELTA;
          end
        end
        default: stage = PH_DELTA;
      endcase
      if (last) begin
        emit(KIND_END, 7'd0, 7'd0, 24'd0, ERR_NONE);
        clear_parser();
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last_result = 1'b1;
      foreach (fresh[i]) pending_events.insert(pending_events.size(), fresh[i]);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        failures++;
        // keep the log short when the block is badly broken
        if (failures <= REPORT_LIMIT)
          $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_event(result_t got);
      result_t want;
      if (pending_events.size() == 0) begin
        failures++;
        if (failures <= REPORT_LIMIT)
          $display("%0t: unexpected result: expected none, actual kind %0d tick 0x%0h",
                   $time, got.kind, got.tick_time);
        return;
      end
      want = pending_events.pop_front();
      compare_field("kind", 32'(want.kind), 32'(got.kind));
      compare_field("tick_time", want.tick_time, got.tick_time);
      compare_field("channel", 32'(want.channel), 32'(got.channel));
      compare_field("key", 32'(want.key), 32'(got.key));
      compare_field("velocity", 32'(want.velocity), 32'(got.velocity));
      compare_field("tempo", 32'(want.tempo), 32'(got.tempo));
      compare_field("error_code", 32'(want.error_code), 32'(got.error_code));
      compare_field("last_result", 32'(want.last_result), 32'(got.last_result));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mtp_byte_if   track();
  mtp_result_if events();

  midi_track_note_tempo_parser_top i_dut (
    .clk     (clk),
    .rst     (rst),
    .track   (track),
    .events  (events),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  track_event_scoreboard sb;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count;
  int unsigned phase_bytes;
  logic [7:0]  track_bytes[$];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("midi_track_note_tempo_parser_top test failed");
    $finish;
  end

  initial begin
    events.ready = 1'b0;
    forever begin
      @(negedge clk);
      events.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (!rst && events.valid && events.ready) begin
      got.kind = events.kind;
      got.tick_time = events.tick_time;
      got.channel = events.channel;
      got.key = events.key;
      got.velocity = events.velocity;
      got.tempo = events.tempo;
      got.error_code = events.error_code;
      got.last_result = events.last_result;
      sb.check_event(got);
    end
  end

  // entered and left just after a falling edge
  task automatic put_byte(input logic [7:0] b, input bit last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      track.valid <= 1'b0;
      @(negedge clk);
    end
    track.valid <= 1'b1;
    track.data_byte <= b;
    track.last_byte <= last;
    @(posedge clk);
    while (!track.ready) @(posedge clk);
    sb.take_byte(b, last);
    @(negedge clk);
  endtask

  task automatic send_track();
    foreach (track_bytes[i]) put_byte(track_bytes[i], i == track_bytes.size() - 1);
    phase_bytes += track_bytes.size();
  endtask

  task automatic drain_events();
    track.valid <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_channel_tag(input logic [3:0] tag);
    logic [31:0] word;
    word = $urandom;
    word[3:0] = tag;
    drain_events();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CHANNEL_TAG_ADDR;
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.chan_tag = tag;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [7:0] rand_data();
    return ($urandom_range(19, 0) == 0) ? 8'($urandom) : 8'($urandom_range(127, 0));
  endfunction

  function automatic int unsigned rand_length();
    return ($urandom_range(19, 0) == 0) ? $urandom_range(200, 128) : $urandom_range(6, 0);
  endfunction

  function automatic void add_byte(input logic [7:0] b);
    track_bytes.insert(track_bytes.size(), b);
  endfunction

  function automatic void add_vlq(logic [31:0] v);
    logic [7:0] enc[$];
    enc.push_front({1'b0, v[6:0]});
    v = v >> 7;
    while (v != 0) begin
      enc.push_front({1'b1, v[6:0]});
      v = v >> 7;
    end
    foreach (enc[i]) add_byte(enc[i]);
  endfunction

  // length field followed by that many bytes to skip
  function automatic void add_length(int unsigned n);
    if ($urandom_range(9, 0) == 0 && n < 128) begin
      // top bits fall out of the 28-bit length
      add_byte({1'b1, 7'($urandom_range(127, 1))});
      repeat (3) add_byte(8'h80);
      add_byte(8'(n));
    end else begin
      add_vlq(n);
    end
    repeat (n) add_byte(8'($urandom));
  endfunction

  task automatic run_phase(input int unsigned idle, input int unsigned stall,
                           input bit pause_midway);
    int unsigned pick;
    int unsigned n;
    logic [7:0]  status;
    bit          status_ok;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    phase_bytes = 0;
    while (phase_bytes < PHASE_BYTES) begin
      if (pause_midway && phase_bytes >= PHASE_BYTES / 2) begin
        drain_events();
        pause_midway = 1'b0;
      end
      track_bytes.delete();
      status = '0;
      status_ok = 1'b0;
      repeat ($urandom_range(12, 1)) begin
        pick = $urandom_range(99, 0);
        if (pick < 60) add_vlq($urandom_range(127, 0));
        else if (pick < 85) add_vlq($urandom_range(16383, 0));
        else if (pick < 95) add_vlq($urandom);
        else begin
          // overlong delta wraps the accumulator
          repeat ($urandom_range(6, 4)) add_byte({1'b1, 7'($urandom)});
          add_byte({1'b0, 7'($urandom)});
        end

        pick = $urandom_range(99, 0);
        if (pick < 30) begin
          status = 8'($urandom_range(ST_NOTE_LAST, 8'h80));
          status_ok = 1'b1;
          add_byte(status);
          add_byte(rand_data());
          add_byte(($urandom_range(9, 0) == 0) ? 8'h00 : rand_data());
        end else if (pick < 45) begin
          // running status; without one this is the no-status error
          add_byte(8'($urandom_range(127, 0)));
          if (status_ok && !(status >= ST_ONE_DATA && status < ST_TWO_DATA))
            add_byte(rand_data());
        end else if (pick < 57) begin
          status = 8'($urandom_range(8'hEF, 8'hA0));
          status_ok = 1'b1;
          add_byte(status);
          add_byte(rand_data());
          if (!(status >= ST_ONE_DATA && status < ST_TWO_DATA))
            add_byte(rand_data());
        end else if (pick < 72) begin
          status_ok = 1'b0;
          add_byte(ST_META);
          add_byte(META_TEMPO);
          if ($urandom_range(4, 0) != 0) begin
            add_byte(TEMPO_LENGTH);
            repeat (3) add_byte(8'($urandom));
          end else begin
            n = $urandom_range(5, 0);
            if (n >= 3) n++;
            add_length(n);
          end
        end else if (pick < 82) begin
          status_ok = 1'b0;
          add_byte(ST_META);
          n = $urandom_range(255, 0);
          add_byte((n == META_TEMPO) ? 8'h2F : 8'(n));
          add_length(rand_length());
        end else if (pick < 92) begin
          status_ok = 1'b0;
          add_byte(8'($urandom_range(8'hFE, ST_SYSTEM)));
          add_length(rand_length());
        end else begin
          repeat ($urandom_range(4, 1)) add_byte(8'($urandom));
        end
      end
      // some tracks stop in the middle of an event
      if ($urandom_range(7, 0) == 0) begin
        n = $urandom_range(track_bytes.size(), 1);
        while (track_bytes.size() > n) void'(track_bytes.pop_back());
      end
      send_track();
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    track.valid = 1'b0;
    track.data_byte = '0;
    track.last_byte = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    track_bytes = '{
      // wrapping delta, note on with top bit set in the key byte
      8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h93, 8'hFF, 8'h7F,
      // running status note on with velocity zero
      8'h00, 8'h3C, 8'h00,
      // note off
      8'h00, 8'h85, 8'h80, 8'h7F,
      // tempo
      8'h00, 8'hFF, 8'h51, 8'h03, 8'h00, 8'hFF, 8'h00,
      // empty sysex clears running status, so the next data byte is an error
      8'h00, 8'hF0, 8'h00,
      8'h00, 8'h12,
      // tempo length error and end of track on the same transfer
      8'h00, 8'hFF, 8'h51, 8'h00
    };
    send_track();

    run_phase(0, 0, 1'b0);
    write_channel_tag(4'hF);
    run_phase(51, 0, 1'b0);
    write_channel_tag(4'($urandom_range(14, 1)));
    run_phase(0, 51, 1'b1);
    write_channel_tag(4'h0);
    run_phase(26, 26, 1'b0);

    drain_events();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0) begin
      $display("midi_track_note_tempo_parser_top test passed");
    end else begin
      $display("midi_track_note_tempo_parser_top test failed");
    end
    $finish;
  end

endmodule
